// ----- hw/rtl/tss_pkg.sv -----
// Package for the triangle scanline span block: widths, pipeline depths and
// the item types shared by the setup, divider, interpolation and top modules.
// Depends on nothing.
package tss_pkg;

  localparam int CFB = 4;
  localparam int CIB = 12;
  localparam int RFB = 16;

  localparam int CW   = CIB + CFB;
  localparam int RW   = CIB;
  localparam int XW   = 12;
  localparam int DYW  = CW + 1;
  localparam int DMW  = CW;
  localparam int HW   = CW;
  localparam int QW   = DMW + RFB;
  localparam int PW   = QW + CW;
  localparam int MW   = PW - RFB;
  localparam int TW   = MW + 2;

  localparam int DIV_STAGES    = QW;
  localparam int INTERP_STAGES = 3;
  localparam int PIPE_D        = DIV_STAGES + INTERP_STAGES;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } vtx_t;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] ex;
    logic [CW-1:0]        dxmag;
    logic                 dxneg;
    logic                 tneg;
    logic                 hz;
  } edge_meta_t;

  typedef struct packed {
    logic [DMW-1:0] dmag;
    logic [HW-1:0]  h;
    edge_meta_t     meta;
  } edge_in_t;

  typedef struct packed {
    logic valid;
    logic up;
    logic lo;
  } item_flags_t;

endpackage

// ----- hw/rtl/tss_setup.sv -----
// Input stage: sorts the vertices by y, decides which halves hold the row
// and prepares the long edge and both short edges for division. Depends on tss_pkg.
module tss_setup (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        accept_i,
  input  tss_pkg::vtx_t               va_i,
  input  tss_pkg::vtx_t               vb_i,
  input  tss_pkg::vtx_t               vc_i,
  input  logic signed [tss_pkg::RW-1:0] row_i,
  output tss_pkg::item_flags_t        flags_o,
  output tss_pkg::edge_in_t           long_o,
  output tss_pkg::edge_in_t           su_o,
  output tss_pkg::edge_in_t           sl_o
);
  import tss_pkg::*;

  function automatic logic signed [RW-1:0] trunc_y(logic signed [CW-1:0] y);
    logic signed [CW-1:0] b;
    b = y[CW-1] ? y + CW'((1 << CFB) - 1) : y;
    return RW'(b >>> CFB);
  endfunction

  function automatic edge_in_t mk_edge(vtx_t s, vtx_t e, logic signed [RW-1:0] r);
    logic signed [DYW-1:0] dy;
    logic signed [CW:0]    hh;
    logic signed [CW:0]    dx;
    edge_in_t              o;
    dy = ({{(DYW-RW){r[RW-1]}}, r} <<< CFB) - {s.y[CW-1], s.y};
    hh = {e.y[CW-1], e.y} - {s.y[CW-1], s.y};
    dx = {e.x[CW-1], e.x} - {s.x[CW-1], s.x};
    o.dmag       = dy[DYW-1] ? DMW'(-dy) : DMW'(dy);
    o.h          = HW'(hh);
    o.meta.sx    = s.x;
    o.meta.ex    = e.x;
    o.meta.dxmag = dx[CW] ? CW'(-dx) : CW'(dx);
    o.meta.dxneg = dx[CW];
    o.meta.tneg  = dy[DYW-1];
    o.meta.hz    = (hh == '0);
    return o;
  endfunction

  vtx_t a1, b1, b2, c2, a3, b3;
  logic signed [RW-1:0] y0, y1, y2;
  logic flat, up, lo;
  item_flags_t flags_q;
  edge_in_t long_q, su_q, sl_q;

  always_comb begin
    a1 = (va_i.y > vb_i.y) ? vb_i : va_i;
    b1 = (va_i.y > vb_i.y) ? va_i : vb_i;
    b2 = (b1.y > vc_i.y) ? vc_i : b1;
    c2 = (b1.y > vc_i.y) ? b1 : vc_i;
    a3 = (a1.y > b2.y) ? b2 : a1;
    b3 = (a1.y > b2.y) ? a1 : b2;
    y0 = trunc_y(a3.y);
    y1 = trunc_y(b3.y);
    y2 = trunc_y(c2.y);
    flat = (c2.y == a3.y);
    up = !flat && (row_i >= y0) && (row_i <= y1);
    lo = !flat && (row_i >= y1) && (row_i <= y2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (en_i) begin
      flags_q.valid <= accept_i;
      flags_q.up    <= up;
      flags_q.lo    <= lo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      long_q <= mk_edge(a3, c2, row_i);
      su_q   <= mk_edge(a3, b3, row_i);
      sl_q   <= mk_edge(b3, c2, row_i);
    end
  end

  assign flags_o = flags_q;
  assign long_o  = long_q;
  assign su_o    = su_q;
  assign sl_o    = sl_q;

endmodule

// ----- hw/rtl/tss_div.sv -----
// Pipelined restoring divider for one edge, one quotient bit per stage,
// with the edge data carried alongside. Depends on tss_pkg.
module tss_div (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  tss_pkg::edge_in_t        edge_i,
  output logic [tss_pkg::QW-1:0]   quo_o,
  output tss_pkg::edge_meta_t      meta_o
);
  import tss_pkg::*;

  logic [HW-1:0]  rem_q [QW];
  logic [QW-1:0]  pq_q  [QW];
  logic [HW-1:0]  h_q   [QW];
  edge_meta_t     meta_q[QW];
  logic [HW-1:0]  rem_d [QW];
  logic [QW-1:0]  pq_d  [QW];

  always_comb begin
    for (int i = 0; i < QW; i++) begin
      logic [HW-1:0] rs;
      logic [QW-1:0] ps;
      logic [HW-1:0] hs;
      logic [HW:0]   r2;
      logic          ge;
      rs = (i == 0) ? '0 : rem_q[(i == 0) ? 0 : i - 1];
      ps = (i == 0) ? {edge_i.dmag, {RFB{1'b0}}} : pq_q[(i == 0) ? 0 : i - 1];
      hs = (i == 0) ? edge_i.h : h_q[(i == 0) ? 0 : i - 1];
      r2 = {rs, ps[QW-1]};
      ge = (r2 >= {1'b0, hs});
      rem_d[i] = ge ? HW'(r2 - {1'b0, hs}) : HW'(r2);
      pq_d[i]  = {ps[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < QW; i++) begin
        rem_q[i] <= rem_d[i];
        pq_q[i]  <= pq_d[i];
      end
      h_q[0]    <= edge_i.h;
      meta_q[0] <= edge_i.meta;
      for (int i = 1; i < QW; i++) begin
        h_q[i]    <= h_q[i-1];
        meta_q[i] <= meta_q[i-1];
      end
    end
  end

  assign quo_o  = pq_q[QW-1];
  assign meta_o = meta_q[QW-1];

endmodule

// ----- hw/rtl/tss_interp.sv -----
// Three-stage edge interpolation: ratio times width plus start x, or end x
// for a flat edge; truncate to whole pixels and saturate. Depends on tss_pkg.
module tss_interp (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [tss_pkg::QW-1:0]     quo_i,
  input  tss_pkg::edge_meta_t        meta_i,
  output logic signed [tss_pkg::XW-1:0] x_o
);
  import tss_pkg::*;

  localparam logic signed [TW-1:0] XMIN = -(TW'(1) <<< (XW - 1));
  localparam logic signed [TW-1:0] XMAX = (TW'(1) <<< (XW - 1)) - TW'(1);

  function automatic logic signed [XW-1:0] trunc_sat(logic signed [TW-1:0] v);
    logic signed [TW-1:0] b;
    logic signed [TW-1:0] t;
    b = v[TW-1] ? v + TW'((1 << CFB) - 1) : v;
    t = b >>> CFB;
    if (t < XMIN) return XW'(XMIN);
    if (t > XMAX) return XW'(XMAX);
    return XW'(t);
  endfunction

  logic [PW-1:0]        prod_q;
  edge_meta_t           m1_q, m2_q;
  logic signed [TW-1:0] xq_q;
  logic signed [XW-1:0] x_q;
  logic [MW-1:0]        mag;
  logic signed [TW-1:0] term;
  logic signed [TW-1:0] xq_d;

  always_comb begin
    mag  = MW'(prod_q >> RFB);
    term = (m1_q.tneg ^ m1_q.dxneg) ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    xq_d = term + {{(TW-CW){m1_q.sx[CW-1]}}, m1_q.sx};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PW'(quo_i) * PW'(meta_i.dxmag);
      m1_q   <= meta_i;
      xq_q   <= xq_d;
      m2_q   <= m1_q;
      x_q    <= m2_q.hz ? trunc_sat({{(TW-CW){m2_q.ex[CW-1]}}, m2_q.ex})
                        : trunc_sat(xq_q);
    end
  end

  assign x_o = x_q;

endmodule

// ----- hw/rtl/triangle_scanline_span.sv -----
// Top level of the triangle scanline span block: setup, an edge divider and
// an interpolator for each edge, and the result sequencer. Depends on tss_pkg.
//
// One item (three vertices and a row) is taken at each rising edge where start
// is high and busy is low. Its results pass through one setup stage, 32 divider
// stages and three interpolation stages and appear one per cycle, marked by
// result_valid_o. The receiver cannot stall. A row shared by both halves gives
// two results. The first is shown in a cycle during which busy is high and the
// whole pipeline holds, and the second follows in the next cycle. Such items
// hold the pipeline while their first result is shown; all others do not.
module triangle_scanline_span (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [tss_pkg::CW-1:0]  vert_a_x_i,
  input  logic signed [tss_pkg::CW-1:0]  vert_a_y_i,
  input  logic signed [tss_pkg::CW-1:0]  vert_b_x_i,
  input  logic signed [tss_pkg::CW-1:0]  vert_b_y_i,
  input  logic signed [tss_pkg::CW-1:0]  vert_c_x_i,
  input  logic signed [tss_pkg::CW-1:0]  vert_c_y_i,
  input  logic signed [tss_pkg::RW-1:0]  row_i,
  output logic                           result_valid_o,
  output logic                           covered_o,
  output logic signed [tss_pkg::XW-1:0]  span_left_o,
  output logic signed [tss_pkg::XW-1:0]  span_right_o,
  output logic                           last_o
);
  import tss_pkg::*;

  logic en, stall, phase_q;
  vtx_t va, vb, vc;
  item_flags_t s_flags, fin;
  item_flags_t flags_q [PIPE_D];
  edge_in_t e_long, e_su, e_sl;
  logic [QW-1:0] q_long, q_su, q_sl;
  edge_meta_t m_long, m_su, m_sl;
  logic signed [XW-1:0] x_long, x_su, x_sl, xa, xb;

  assign va = '{x: vert_a_x_i, y: vert_a_y_i};
  assign vb = '{x: vert_b_x_i, y: vert_b_y_i};
  assign vc = '{x: vert_c_x_i, y: vert_c_y_i};

  assign fin   = flags_q[PIPE_D-1];
  assign stall = fin.valid && fin.up && fin.lo && !phase_q;
  assign en    = !stall;
  assign busy  = stall;

  tss_setup u_setup (
    .clk_i, .rst_ni, .en_i(en), .accept_i(start && !busy),
    .va_i(va), .vb_i(vb), .vc_i(vc), .row_i,
    .flags_o(s_flags), .long_o(e_long), .su_o(e_su), .sl_o(e_sl)
  );

  tss_div u_div_long (.clk_i, .en_i(en), .edge_i(e_long), .quo_o(q_long), .meta_o(m_long));
  tss_div u_div_su   (.clk_i, .en_i(en), .edge_i(e_su),   .quo_o(q_su),   .meta_o(m_su));
  tss_div u_div_sl   (.clk_i, .en_i(en), .edge_i(e_sl),   .quo_o(q_sl),   .meta_o(m_sl));

  tss_interp u_int_long (.clk_i, .en_i(en), .quo_i(q_long), .meta_i(m_long), .x_o(x_long));
  tss_interp u_int_su   (.clk_i, .en_i(en), .quo_i(q_su),   .meta_i(m_su),   .x_o(x_su));
  tss_interp u_int_sl   (.clk_i, .en_i(en), .quo_i(q_sl),   .meta_i(m_sl),   .x_o(x_sl));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIPE_D; i++) flags_q[i] <= '0;
      phase_q <= 1'b0;
    end else begin
      phase_q <= stall;
      if (en) begin
        flags_q[0] <= s_flags;
        for (int i = 1; i < PIPE_D; i++) flags_q[i] <= flags_q[i-1];
      end
    end
  end

  always_comb begin
    result_valid_o = fin.valid;
    covered_o      = fin.up || fin.lo;
    xa             = x_long;
    xb             = (fin.up && (!fin.lo || !phase_q)) ? x_su : x_sl;
    last_o         = !(fin.up && fin.lo && !phase_q);
    if (!covered_o) begin
      span_left_o  = '0;
      span_right_o = '0;
    end else if (xa > xb) begin
      span_left_o  = xb;
      span_right_o = xa;
    end else begin
      span_left_o  = xa;
      span_right_o = xb;
    end
  end

  a_split_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> phase_q && result_valid_o && last_o)
    else $error("second span of a shared row not shown");

  a_uncov_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !covered_o |-> last_o && span_left_o == '0 && span_right_o == '0)
    else $error("uncovered result malformed");

  a_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> span_left_o <= span_right_o)
    else $error("span not ordered");

  a_phase_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> !busy)
    else $error("pipeline held for more than one cycle");

endmodule

// ----- test/tb_top.sv -----
// Testbench for triangle_scanline_span: drives triangle/row items through the
// start/busy handshake and checks every span against a predictor of the fill.
// Depends on tss_pkg and the triangle_scanline_span RTL.
`timescale 1ns / 100ps

class span_board;
  typedef struct {
    bit                 covered;
    logic signed [11:0] left;
    logic signed [11:0] right;
    bit                 last;
  } span_t;

  span_t pending[$];
  int    errors;

  function longint trunc16(longint q);
    return q / 16;
  endfunction

  function longint sat_x(longint v);
    if (v < -2048) return -2048;
    if (v > 2047) return 2047;
    return v;
  endfunction

  function longint edge_x(longint sx, longint sy, longint ex, longint ey, longint row);
    longint h, dy, t, xq;
    h = ey - sy;
    if (h <= 0) return sat_x(trunc16(ex));
    dy = row * 16 - sy;
    t  = (dy * 65536) / h;
    xq = sx + (t * (ex - sx)) / 65536;
    return sat_x(trunc16(xq));
  endfunction

  function void push_span(bit cov, longint l, longint r, bit lst);
    span_t s;
    s.covered = cov;
    s.left    = (l > r) ? r[11:0] : l[11:0];
    s.right   = (l > r) ? l[11:0] : r[11:0];
    s.last    = lst;
    pending.push_back(s);
  endfunction

  function void note_item(longint vx[3], longint vy[3], longint row);
    longint tx, ty, y0, y1, y2;
    bit up, lo;
    for (int p = 0; p < 3; p++) begin
      int a;
      a = (p == 1) ? 1 : 0;
      if (vy[a] > vy[a+1]) begin
        tx = vx[a]; vx[a] = vx[a+1]; vx[a+1] = tx;
        ty = vy[a]; vy[a] = vy[a+1]; vy[a+1] = ty;
      end
    end
    y0 = trunc16(vy[0]);
    y1 = trunc16(vy[1]);
    y2 = trunc16(vy[2]);
    up = (vy[2] != vy[0]) && row >= y0 && row <= y1;
    lo = (vy[2] != vy[0]) && row >= y1 && row <= y2;
    if (!up && !lo) push_span(1'b0, 0, 0, 1'b1);
    if (up)
      push_span(1'b1, edge_x(vx[0], vy[0], vx[2], vy[2], row),
                edge_x(vx[0], vy[0], vx[1], vy[1], row), !lo);
    if (lo)
      push_span(1'b1, edge_x(vx[0], vy[0], vx[2], vy[2], row),
                edge_x(vx[1], vy[1], vx[2], vy[2], row), 1'b1);
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task check_span(bit cov, logic signed [11:0] l, logic signed [11:0] r, bit lst);
    span_t s;
    if (pending.size() == 0) begin
      report("unexpected result");
      return;
    end
    s = pending.pop_front();
    if (cov !== s.covered) report($sformatf("covered %0b want %0b", cov, s.covered));
    if (l !== s.left) report($sformatf("span_left %0d want %0d", l, s.left));
    if (r !== s.right) report($sformatf("span_right %0d want %0d", r, s.right));
    if (lst !== s.last) report($sformatf("last %0b want %0b", lst, s.last));
  endtask
endclass

module tb_top;
  import tss_pkg::*;

  logic clk_i, rst_ni, start, busy;
  logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
  logic signed [RW-1:0] row;
  logic result_valid_o, covered_o, last_o;
  logic signed [XW-1:0] span_left_o, span_right_o;

  span_board board;
  int burst;

  triangle_scanline_span u_top (
    .clk_i, .rst_ni, .start, .busy,
    .vert_a_x_i(ax), .vert_a_y_i(ay), .vert_b_x_i(bx), .vert_b_y_i(by),
    .vert_c_x_i(cx), .vert_c_y_i(cy), .row_i(row),
    .result_valid_o, .covered_o, .span_left_o, .span_right_o, .last_o
  );

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      board.check_span(covered_o, span_left_o, span_right_o, last_o);
  end

  task send_item(int a_x, int a_y, int b_x, int b_y, int c_x, int c_y, int r);
    longint vx[3], vy[3];
    int gap;
    ax <= CW'(a_x); ay <= CW'(a_y); bx <= CW'(b_x); by <= CW'(b_y);
    cx <= CW'(c_x); cy <= CW'(c_y); row <= RW'(r);
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    vx[0] = longint'(ax); vx[1] = longint'(bx); vx[2] = longint'(cx);
    vy[0] = longint'(ay); vy[1] = longint'(by); vy[2] = longint'(cy);
    board.note_item(vx, vy, longint'(row));
    @(negedge clk_i);
    if (burst > 0) burst--;
    else begin
      gap = int'($urandom_range(0, 4));
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
    end
  endtask

  function int rnd16();
    return $signed(16'($urandom));
  endfunction

  function int small_c();
    return $urandom_range(0, 1600) - 800;
  endfunction

  initial begin
    int ya, yb, yc, lo_r, hi_r;
    board = new();
    rst_ni = 0; start = 0; burst = 0;
    ax = 0; ay = 0; bx = 0; by = 0; cx = 0; cy = 0; row = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    send_item(0, 0, 160, 160, -160, 320, 10);
    send_item(0, 0, 160, 160, -160, 320, 5);
    send_item(0, 0, 160, 160, -160, 320, 15);
    send_item(0, 0, 160, 160, -160, 320, 30);
    send_item(0, 80, 100, 80, 50, 80, 5);
    send_item(0, 0, 160, 0, 80, 160, 0);
    send_item(0, 0, 160, 160, 80, 160, 10);
    send_item(-32768, -32768, 32767, 32767, -32768, 32767, 0);
    send_item(32767, -32768, -32768, 32767, 32767, 0, -2048);
    send_item(-32768, -32768, 32767, 32767, 0, 0, 2047);
    send_item(32767, 32767, -32768, -32768, 32767, -32768, -2048);
    send_item(5, 7, -5, 9, 3, -9, 0);
    send_item(-32768, 32767, 32767, -32768, 0, 100, -1);
    send_item(-1, -1, -1, -1, -1, -1, -1);
    send_item(0, -17, 16, 33, 40, 33, 2);

    for (int n = 0; n < 1900; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
                  $urandom_range(0, 4095) - 2048);
      end else begin
        ya = small_c(); yb = small_c(); yc = small_c();
        if ($urandom_range(0, 7) == 0) yb = ya;
        lo_r = ya; hi_r = ya;
        if (yb < lo_r) lo_r = yb; if (yc < lo_r) lo_r = yc;
        if (yb > hi_r) hi_r = yb; if (yc > hi_r) hi_r = yc;
        lo_r = lo_r / 16 - 2; hi_r = hi_r / 16 + 2;
        if ($urandom_range(0, 5) == 0) yc = yb;
        send_item(small_c(), ya, small_c(), yb, small_c(), yc,
                  ($urandom_range(0, 3) == 0) ? yb / 16
                                              : lo_r + int'($urandom_range(0, hi_r - lo_r)));
      end
    end
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (board.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
